// ===== rtl/pctd_pkg.sv =====
// shared types, character codes and helper functions for the percent decoder
package pctd_pkg;

  // character codes
  localparam logic [7:0] CharPercent = 8'h25;
  localparam logic [7:0] CharPlus    = 8'h2B;
  localparam logic [7:0] CharMinus   = 8'h2D;
  localparam logic [7:0] CharSpace   = 8'h20;

  // escape progress
  typedef enum logic [1:0] {
    PEND_NONE  = 2'd0,
    PEND_PCT   = 2'd1,
    PEND_DIGIT = 2'd2
  } pend_e;

  // input item
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  // result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_run_end;
    logic       out_stream_end;
    logic       out_error;
  } out_t;

  // decoder state carried between items
  typedef struct packed {
    pend_e      pend;
    logic [7:0] first_digit;
    logic       failed;
  } state_t;

  // results of one item, up to two
  typedef struct packed {
    logic [1:0] count;
    out_t       res0;
    out_t       res1;
  } dec_t;

  // hex digit value, msb flags a valid digit
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CharSpace) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic [7:0] plain(input logic [7:0] c);
    return (c == CharPlus) ? CharSpace : c;
  endfunction

endpackage

// ===== rtl/percent_decoder.sv =====
// top level of the streaming url percent decoder
//
// Input channel in_valid_i/in_ready_o carries one encoded byte and a last
// flag per transfer; output channel out_valid_o/out_ready_i carries one
// decoded result per transfer. An input byte gives zero, one or two results.
// Each accepted byte is decoded in the cycle it is taken and its results are
// written into a four-entry result queue, so every result is registered
// before it reaches the output. One byte can be taken in every
// cycle while the receiver keeps up; a byte that gives two results leaves
// one extra entry in the queue, drained at one result per cycle. in_ready_o
// drops while the queue holds more than two results, i.e. when the receiver
// stalls, so no result is ever lost. Reset clears the escape state, the
// error flag and the queue; the block is ready once reset is released.
// After an error result the rest of the stream is dropped up to and
// including the byte flagged last.
module percent_decoder (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  pctd_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output pctd_pkg::out_t out_data_o
);

  pctd_pkg::state_t state_q, state_d, state_nxt;
  pctd_pkg::dec_t   dec, wr;
  logic             room, in_xfer;

  assign in_ready_o = room;
  assign in_xfer    = in_valid_i && room;

  pctd_decode u_decode (
    .item_i  (in_data_i),
    .state_i (state_q),
    .state_o (state_nxt),
    .dec_o   (dec)
  );

  // commit state and results only on an input transfer
  always_comb begin
    state_d = in_xfer ? state_nxt : state_q;
    wr      = dec;
    if (!in_xfer) begin
      wr.count = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{pend: pctd_pkg::PEND_NONE, first_digit: 8'd0, failed: 1'b0};
    end else begin
      state_q <= state_d;
    end
  end

  pctd_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (wr),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/pctd_decode.sv =====
// combinational decode of one byte against the current escape state
module pctd_decode (
  input  pctd_pkg::in_t    item_i,
  input  pctd_pkg::state_t state_i,
  output pctd_pkg::state_t state_o,
  output pctd_pkg::dec_t   dec_o
);

  logic [4:0] h1, h2;
  logic [7:0] esc_byte;
  logic       esc_neg;

  // two-digit escape value, strtol style
  always_comb begin
    h1       = pctd_pkg::hex_digit(state_i.first_digit);
    h2       = pctd_pkg::hex_digit(item_i.in_byte);
    esc_byte = 8'd0;
    esc_neg  = 1'b0;
    if (h1[4]) begin
      esc_byte = h2[4] ? {h1[3:0], h2[3:0]} : {4'd0, h1[3:0]};
    end else if (h2[4]) begin
      if (pctd_pkg::is_ws(state_i.first_digit) ||
          state_i.first_digit == pctd_pkg::CharPlus) begin
        esc_byte = {4'd0, h2[3:0]};
      end else if (state_i.first_digit == pctd_pkg::CharMinus) begin
        esc_neg = (h2[3:0] != 4'd0);
      end
    end
  end

  // next state and results
  always_comb begin
    logic last;
    logic neg_hit;
    last    = item_i.in_last;
    neg_hit = 1'b0;
    state_o = state_i;
    dec_o   = '0;
    if (state_i.failed) begin
      if (last) begin
        state_o.failed = 1'b0;
        state_o.pend   = pctd_pkg::PEND_NONE;
      end
    end else begin
      unique case (state_i.pend)
        pctd_pkg::PEND_PCT: begin
          if (last) begin
            dec_o.count         = 2'd2;
            dec_o.res0.out_byte = pctd_pkg::CharPercent;
            dec_o.res1.out_byte = pctd_pkg::plain(item_i.in_byte);
          end else begin
            state_o.first_digit = item_i.in_byte;
            state_o.pend        = pctd_pkg::PEND_DIGIT;
          end
        end
        pctd_pkg::PEND_DIGIT: begin
          state_o.pend = pctd_pkg::PEND_NONE;
          dec_o.count  = 2'd1;
          if (esc_neg) begin
            neg_hit                   = 1'b1;
            dec_o.res0.out_error      = 1'b1;
            dec_o.res0.out_run_end    = 1'b1;
            dec_o.res0.out_stream_end = 1'b1;
            state_o.failed            = !last;
          end else begin
            dec_o.res0.out_byte = esc_byte;
          end
        end
        default: begin
          state_o.pend = pctd_pkg::PEND_NONE;
          if (item_i.in_byte == pctd_pkg::CharPercent) begin
            if (last) begin
              dec_o.count         = 2'd1;
              dec_o.res0.out_byte = pctd_pkg::CharPercent;
            end else begin
              state_o.pend = pctd_pkg::PEND_PCT;
            end
          end else begin
            dec_o.count         = 2'd1;
            dec_o.res0.out_byte = pctd_pkg::plain(item_i.in_byte);
          end
        end
      endcase
      if (last) begin
        state_o.pend = pctd_pkg::PEND_NONE;
      end
      // flag the last result of this item
      if (!neg_hit) begin
        if (dec_o.count == 2'd1) begin
          dec_o.res0.out_run_end    = 1'b1;
          dec_o.res0.out_stream_end = last;
        end else if (dec_o.count == 2'd2) begin
          dec_o.res1.out_run_end    = 1'b1;
          dec_o.res1.out_stream_end = last;
        end
      end
    end
  end

endmodule

// ===== rtl/pctd_outq.sv =====
// four-entry result queue, writes up to two results and reads one per cycle while the receiver is ready
module pctd_outq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  pctd_pkg::dec_t wr_i,
  output logic           room_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output pctd_pkg::out_t out_data_o
);

  localparam int Depth = 4;
  localparam int PtrW  = $clog2(Depth);

  pctd_pkg::out_t  mem_q [Depth];
  logic [PtrW-1:0] head_q, head_d, tail_q, tail_d;
  logic [PtrW:0]   cnt_q, cnt_d;
  logic            rd;

  assign room_o      = (cnt_q <= (PtrW+1)'(Depth - 2));
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[head_q];
  assign rd          = out_valid_o && out_ready_i;

  // pointer and fill update
  always_comb begin
    tail_d = tail_q + PtrW'(wr_i.count);
    head_d = head_q + PtrW'(rd);
    cnt_d  = cnt_q + (PtrW+1)'(wr_i.count) - (PtrW+1)'(rd);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
    end
  end

  // result storage
  always_ff @(posedge clk_i) begin
    if (wr_i.count != 2'd0) begin
      mem_q[tail_q] <= wr_i.res0;
    end
    if (wr_i.count == 2'd2) begin
      mem_q[tail_q + PtrW'(1)] <= wr_i.res1;
    end
  end

endmodule

// ===== rtl/pctd_checker.sv =====
// port-level checks for the percent decoder and their binding
module pctd_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input pctd_pkg::out_t out_data_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // error result is a zero byte that ends the stream
  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.out_error |->
      out_data_o.out_byte == 8'd0 && out_data_o.out_stream_end)
    else $error("malformed error result");

  // stream end is always the end of a run
  a_end_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.out_stream_end |-> out_data_o.out_run_end)
    else $error("stream end without run end");

  // input backpressure only while results wait
  a_ready_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with empty output");

endmodule

bind percent_decoder pctd_checker u_pctd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// ===== bench/percent_decoder_test.sv =====
// self-checking testbench for the streaming url percent decoder
module percent_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchdogLimit = 1000;
  localparam int DrainCycles   = 8;
  localparam int PhaseBytes    = 115;

  // predicts decoded results and checks them in order
  class decode_scoreboard;
    pctd_pkg::pend_e pend;
    logic [7:0]      held_digit;
    bit              dropping;
    pctd_pkg::out_t  decoded_q[$];
    int              errors;
    int              live_bytes;

    function new();
      pend       = pctd_pkg::PEND_NONE;
      held_digit = '0;
      dropping   = 1'b0;
      errors     = 0;
      live_bytes = 0;
    endfunction

    // value of a hex digit, -1 when the byte is not one
    function int nibble_of(logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
      if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
      if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
      return -1;
    endfunction

    // two escape bytes read like a base 16 strtol, range -15..255
    function int escape_code(logic [7:0] c1, logic [7:0] c2);
      int h1;
      int h2;
      h1 = nibble_of(c1);
      h2 = nibble_of(c2);
      if (h1 >= 0) return (h2 >= 0) ? h1 * 16 + h2 : h1;
      if (h2 < 0) return 0;
      if (c1 == pctd_pkg::CharPlus || c1 == pctd_pkg::CharSpace ||
          (c1 >= 8'h09 && c1 <= 8'h0D)) return h2;
      if (c1 == pctd_pkg::CharMinus) return -h2;
      return 0;
    endfunction

    function pctd_pkg::out_t result_of(logic [7:0] b);
      pctd_pkg::out_t r;
      r          = '0;
      r.out_byte = b;
      return r;
    endfunction

    // note one accepted input transfer and queue what it decodes to
    function void take_byte(pctd_pkg::in_t it);
      pctd_pkg::out_t res[$];
      pctd_pkg::out_t r;
      logic [7:0]     plain_b;
      int             v;
      plain_b = (it.in_byte == pctd_pkg::CharPlus) ? pctd_pkg::CharSpace : it.in_byte;
      // rest of a failed stream is dropped up to its last byte
      if (dropping) begin
        if (it.in_last) begin
          dropping = 1'b0;
          pend     = pctd_pkg::PEND_NONE;
        end
        return;
      end
      live_bytes++;
      case (pend)
        pctd_pkg::PEND_PCT: begin
          if (it.in_last) begin
            res.push_back(result_of(pctd_pkg::CharPercent));
            res.push_back(result_of(plain_b));
          end else begin
            held_digit = it.in_byte;
            pend       = pctd_pkg::PEND_DIGIT;
          end
        end
        pctd_pkg::PEND_DIGIT: begin
          v    = escape_code(held_digit, it.in_byte);
          pend = pctd_pkg::PEND_NONE;
          // negative escape ends the stream with an error result
          if (v < 0) begin
            r                = '0;
            r.out_error      = 1'b1;
            r.out_run_end    = 1'b1;
            r.out_stream_end = 1'b1;
            decoded_q.push_back(r);
            dropping = !it.in_last;
            return;
          end
          res.push_back(result_of(v[7:0]));
        end
        default: begin
          pend = pctd_pkg::PEND_NONE;
          if (it.in_byte == pctd_pkg::CharPercent) begin
            if (it.in_last) res.push_back(result_of(pctd_pkg::CharPercent));
            else pend = pctd_pkg::PEND_PCT;
          end else begin
            res.push_back(result_of(plain_b));
          end
        end
      endcase
      if (it.in_last) pend = pctd_pkg::PEND_NONE;
      if (res.size() > 0) begin
        res[res.size()-1].out_run_end    = 1'b1;
        res[res.size()-1].out_stream_end = it.in_last;
      end
      foreach (res[i]) decoded_q.push_back(res[i]);
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    // compare one output transfer with the oldest prediction
    task match_result(pctd_pkg::out_t got);
      pctd_pkg::out_t want;
      if (decoded_q.size() == 0) begin
        report($sformatf("result %h arrived with nothing expected", got));
        return;
      end
      want = decoded_q.pop_front();
      if (got.out_byte !== want.out_byte)
        report($sformatf("out_byte %h, expected %h", got.out_byte, want.out_byte));
      if (got.out_run_end !== want.out_run_end)
        report($sformatf("out_run_end %b, expected %b", got.out_run_end, want.out_run_end));
      if (got.out_stream_end !== want.out_stream_end)
        report($sformatf("out_stream_end %b, expected %b",
                         got.out_stream_end, want.out_stream_end));
      if (got.out_error !== want.out_error)
        report($sformatf("out_error %b, expected %b", got.out_error, want.out_error));
    endtask
  endclass

  logic           clk       = 1'b0;
  logic           rst_n     = 1'b0;
  logic           in_valid  = 1'b0;
  logic           in_ready;
  pctd_pkg::in_t  in_data   = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  pctd_pkg::out_t out_data;

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int idle_cycles    = 0;

  decode_scoreboard board;

  percent_decoder DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // receiver side: random stalls, check each output transfer
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.match_result(out_data);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("[%0t] no transfer for %0d cycles", $realtime, WatchdogLimit);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // one input transfer, entered and left at a falling edge
  task automatic send_byte(logic [7:0] b, bit last);
    pctd_pkg::in_t it;
    it.in_byte = b;
    it.in_last = last;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    board.take_byte(it);
    @(negedge clk);
  endtask

  // a whole stream, last flag on its final byte
  task automatic send_bytes(logic [7:0] octets[$]);
    foreach (octets[i]) send_byte(octets[i], i == octets.size() - 1);
  endtask

  // byte for an escape position, biased toward what strtol cares about
  function automatic logic [7:0] escape_char();
    string hex_chars;
    int    idx;
    hex_chars = "0123456789abcdefABCDEF";
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return hex_chars[$urandom_range(21)];
      5: begin
        idx = $urandom_range(5);
        return (idx == 5) ? pctd_pkg::CharSpace : 8'(8'h09 + idx);
      end
      6: return pctd_pkg::CharPlus;
      7: return pctd_pkg::CharMinus;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // mostly escapes with random content; cutting at the length leaves truncated ones
  task automatic send_random_stream();
    logic [7:0] octets[$];
    int         len;
    len = $urandom_range(1, 16);
    while (octets.size() < len) begin
      case ($urandom_range(9))
        0, 1: octets.push_back(8'($urandom_range(255)));
        2: octets.push_back(pctd_pkg::CharPlus);
        3: octets.push_back(pctd_pkg::CharPercent);
        4: octets.push_back($urandom_range(1) ? 8'h00 : 8'hFF);
        default: begin
          octets.push_back(pctd_pkg::CharPercent);
          octets.push_back(escape_char());
          octets.push_back(escape_char());
        end
      endcase
    end
    while (octets.size() > len) void'(octets.pop_back());
    send_bytes(octets);
  endtask

  task automatic run_phase(int src_pct, int sink_pct, int live_target);
    int start;
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    start          = board.live_bytes;
    while (board.live_bytes - start < live_target) send_random_stream();
  endtask

  initial begin
    logic [7:0] octets[$];
    board = new();
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // directed: plain extremes, plus, escapes incl. leading space and odd digits
    octets = {8'h00, pctd_pkg::CharPlus, pctd_pkg::CharPercent, 8'h34, 8'h31,
              pctd_pkg::CharPercent, 8'h37, pctd_pkg::CharPercent,
              pctd_pkg::CharPercent, pctd_pkg::CharSpace, 8'h61,
              pctd_pkg::CharPercent, 8'h7A, 8'h39, 8'hFF};
    send_bytes(octets);
    // percent as the last byte
    octets = {pctd_pkg::CharPercent};
    send_bytes(octets);
    // percent followed only by the last byte
    octets = {pctd_pkg::CharPercent, pctd_pkg::CharPlus};
    send_bytes(octets);
    // negative escape, then the rest of the stream is dropped
    octets = {pctd_pkg::CharPercent, pctd_pkg::CharMinus, 8'h35, 8'h78,
              pctd_pkg::CharPercent, 8'h79};
    send_bytes(octets);

    // random streams under each idling pattern
    run_phase(0, 0, PhaseBytes);
    run_phase(48, 0, PhaseBytes);
    run_phase(0, 48, PhaseBytes);
    run_phase(14, 14, PhaseBytes);
    in_valid <= 1'b0;

    // drain outstanding results, then let any stray output show up
    while (board.decoded_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (board.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
